### sv/mseu_pkg.sv
package mseu_pkg;

    // Default parameter values of the top level
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // Field widths
    localparam int ELEM_W     = 32;
    localparam int NUM_IN     = 10;
    localparam int IN_DATA_W  = NUM_IN * ELEM_W;
    localparam int LEN_W      = 32;
    localparam int ANGLE_W    = 19;
    localparam int OUT_DATA_W = 160;
    localparam int TOL_W      = 16;

    // Normalized columns are Q2.30
    localparam int Q_NORM = 30;
    localparam int NORM_W = 32;

    // Column length: root of a 64-bit sum of squares
    localparam int LEN_SQ_W = 64;
    localparam int LEN_LAT  = LEN_SQ_W / 2;

    // Cosine term: root of (1 - s*s) in Q.60
    localparam int C_SQ_W = 62;
    localparam int C_W    = C_SQ_W / 2;
    localparam int C_LAT  = C_SQ_W / 2;

    // Normalizing divider: abs stage, one quotient bit a stage, sign stage
    localparam int DIV_Q_W = Q_NORM + 1;
    localparam int DIV_LAT = DIV_Q_W + 2;

    // CORDIC datapath widths
    localparam int CW = 34;
    localparam int ZW = 34;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam longint PI_Q30 = 64'sd3373259426;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REJECT   = 2'd1,
        STATUS_ZERO_LEN = 2'd2
    } status_t;

    // atan(2^-i) in Q.30
    function automatic logic [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return ZW'(v);
    endfunction

endpackage

### sv/mseu_delay.sv
module mseu_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d_i,
    output logic [W-1:0] d_o
);

    logic [W-1:0] tap_reg [D];

    // advance the whole line only when the pipeline moves
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d_i;
            for (int i = 1; i < D; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign d_o = tap_reg[D-1];

endmodule

### sv/mseu_isqrt.sv
module mseu_isqrt import mseu_pkg::*; #(
    parameter int IN_W = LEN_SQ_W
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   rad_i,
    output logic [IN_W/2-1:0] root_o
);

    localparam int STEPS = IN_W / 2;

    logic [IN_W-1:0] rem_reg  [STEPS];
    logic [IN_W-1:0] root_reg [STEPS];

    // one result bit per stage, digit-by-digit square root
    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        localparam int SH = IN_W - 2 - 2 * k;
        logic [IN_W-1:0] rem_in;
        logic [IN_W-1:0] root_in;
        logic [IN_W-1:0] rem_next;
        logic [IN_W-1:0] root_next;
        logic [IN_W:0]   trial;

        if (k == 0) begin : g_first
            assign rem_in  = rad_i;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        always_comb begin
            trial = {1'b0, root_in} + ((IN_W+1)'(1) << SH);
            if ({1'b0, rem_in} >= trial) begin
                rem_next  = rem_in - trial[IN_W-1:0];
                root_next = (root_in >> 1) + (IN_W'(1) << SH);
            end else begin
                rem_next  = rem_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root_o = root_reg[STEPS-1][IN_W/2-1:0];

endmodule

### sv/mseu_div.sv
module mseu_div import mseu_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [ELEM_W-1:0] elem_i,
    input  logic        [LEN_W-1:0]  den_i,
    output logic signed [NORM_W-1:0] quo_o
);

    // quotient = trunc(|elem| * 2^30 / den), |elem| <= den so it fits 31 bits

    logic [ELEM_W-1:0] mag_reg;
    logic [LEN_W-1:0]  den_a_reg;
    logic              neg_a_reg;

    logic [LEN_W:0]       r_reg   [DIV_Q_W];
    logic [DIV_Q_W-1:0]   q_reg   [DIV_Q_W];
    logic [LEN_W-1:0]     den_reg [DIV_Q_W];
    logic                 neg_reg [DIV_Q_W];
    logic signed [NORM_W-1:0] quo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg   <= elem_i[ELEM_W-1] ? (~elem_i + 1'b1) : elem_i;
            den_a_reg <= den_i;
            neg_a_reg <= elem_i[ELEM_W-1];
        end
    end

    for (genvar k = 0; k < DIV_Q_W; k++) begin : g_stage
        logic [LEN_W:0]     r_in;
        logic [DIV_Q_W-1:0] q_in;
        logic [LEN_W-1:0]   den_in;
        logic               neg_in;
        logic [LEN_W:0]     r_next;
        logic               q_bit;

        if (k == 0) begin : g_first
            assign r_in   = {1'b0, mag_reg};
            assign q_in   = '0;
            assign den_in = den_a_reg;
            assign neg_in = neg_a_reg;
        end else begin : g_rest
            assign r_in   = {r_reg[k-1][LEN_W-1:0], 1'b0};
            assign q_in   = q_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        always_comb begin
            if (r_in >= {1'b0, den_in}) begin
                r_next = r_in - {1'b0, den_in};
                q_bit  = 1'b1;
            end else begin
                r_next = r_in;
                q_bit  = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= r_next;
                q_reg[k]   <= {q_in[DIV_Q_W-2:0], q_bit};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    // restore the sign
    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[DIV_Q_W-1]) begin
                quo_reg <= -$signed(NORM_W'(q_reg[DIV_Q_W-1]));
            end else begin
                quo_reg <= $signed(NORM_W'(q_reg[DIV_Q_W-1]));
            end
        end
    end

    assign quo_o = quo_reg;

endmodule

### sv/mseu_cordic.sv
module mseu_cordic import mseu_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [NORM_W-1:0] y_i,
    input  logic signed [NORM_W-1:0] x_i,
    output logic signed [ZW-1:0]     z_o
);

    logic signed [CW-1:0] x_reg  [STEPS+1];
    logic signed [CW-1:0] y_reg  [STEPS+1];
    logic signed [ZW-1:0] z_reg  [STEPS+1];
    logic                 zf_reg [STEPS+1];

    logic signed [CW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] z0;

    // quarter-turn pre-rotation brings x into the right half plane
    always_comb begin
        xs = CW'(x_i);
        ys = CW'(y_i);
        if (xs < 0) begin
            if (ys >= 0) begin
                x0 = ys;
                y0 = -xs;
                z0 = HALF_PI_Q30;
            end else begin
                x0 = -ys;
                y0 = xs;
                z0 = -HALF_PI_Q30;
            end
        end else begin
            x0 = xs;
            y0 = ys;
            z0 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]  <= x0;
            y_reg[0]  <= y0;
            z_reg[0]  <= z0;
            zf_reg[0] <= (x_i == '0) && (y_i == '0);
        end
    end

    // vectoring: drive y toward zero, accumulate the angle
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
        localparam int I = k - 1;
        logic signed [CW-1:0] dx, dy, x_next, y_next;
        logic signed [ZW-1:0] at, z_next;

        always_comb begin
            dx = y_reg[k-1] >>> I;
            dy = x_reg[k-1] >>> I;
            at = $signed(atan_q30(5'(I)));
            if (y_reg[k-1] >= 0) begin
                x_next = x_reg[k-1] + dx;
                y_next = y_reg[k-1] - dy;
                z_next = z_reg[k-1] + at;
            end else begin
                x_next = x_reg[k-1] - dx;
                y_next = y_reg[k-1] + dy;
                z_next = z_reg[k-1] - at;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[k]  <= x_next;
                y_reg[k]  <= y_next;
                z_reg[k]  <= z_next;
                zf_reg[k] <= zf_reg[k-1];
            end
        end
    end

    assign z_o = zf_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

### sv/matrix_scale_euler_decompose.sv
// Channel   Dir  Handshake                Payload
// s_        in   s_tvalid / s_tready      tdata: c0_x c0_y c0_z c1_x c1_y c1_z c2_x c2_y c2_z w_elem
// m_        out  m_tvalid / m_tready      tdata: scales, angles; tuser: status
// cfg_      in   cfg_valid / cfg_ready    zero_tolerance
//
// One item enters per cycle while s_tready is high. Each accepted item passes through
// a 32-stage length root, a 33-stage normalizing divider, a 31-stage cosine root and the
// CORDIC stages before it reaches the output register.
// Reset (aresetn low, synchronous) empties the pipeline and clears zero_tolerance.
// A stall on m_ fills the skid register behind the output register; s_tready then drops
// and the whole pipeline holds, so nothing is lost or repeated.
module matrix_scale_euler_decompose import mseu_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // c0_x, c0_y, c0_z, c1_x, c1_y, c1_z, c2_x, c2_y, c2_z, w_elem (32 bits each)
    input  logic [IN_DATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // scale_x, scale_y, scale_z (32 each), rot_x, rot_y, rot_z (19 each), 7 zero bits
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]            m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TOL_W-1:0]      cfg_data
);

    // Stage indexes of the pipeline, counted from the input register
    localparam int ST_A  = 2 + LEN_LAT;                 // lengths ready
    localparam int ST_B  = ST_A + DIV_LAT;              // normalized columns ready
    localparam int ST_C  = ST_B + 2 + C_LAT;            // cosine term ready
    localparam int ST_D  = ST_C + CORDIC_STEPS + 1;     // angles ready
    localparam int VLD_N = ST_D + 1;

    // Angle rounding to FRAC_BITS and clamping to +-pi and the output range
    localparam int     RND_SH   = Q_NORM - FRAC_BITS;
    localparam longint RND_HALF = 64'sd1 <<< (RND_SH - 1);
    localparam longint PI_LIM   = (PI_Q30 + RND_HALF) >>> RND_SH;
    localparam longint ANG_MAX  = (64'sd1 <<< (ANGLE_W - 1)) - 1;
    localparam longint LIM_HI   = (PI_LIM > ANG_MAX) ? ANG_MAX : PI_LIM;
    localparam longint LIM_LO   = (-PI_LIM < -(ANG_MAX + 1)) ? -(ANG_MAX + 1) : -PI_LIM;
    localparam logic signed [ZW-1:0] HALF_Z = ZW'(RND_HALF);
    localparam logic signed [ZW-1:0] HI_Z   = ZW'(LIM_HI);
    localparam logic signed [ZW-1:0] LO_Z   = ZW'(LIM_LO);

    localparam logic [63:0] UNIT_SQ = 64'd1 << (2 * Q_NORM);

    typedef struct packed {
        logic             rej;
        logic             zero_len;
        logic [LEN_W-1:0] len_z;
        logic [LEN_W-1:0] len_y;
        logic [LEN_W-1:0] len_x;
    } meta_t;

    typedef struct packed {
        status_t                   status;
        logic signed [ANGLE_W-1:0] rot_z;
        logic signed [ANGLE_W-1:0] rot_y;
        logic signed [ANGLE_W-1:0] rot_x;
        logic [LEN_W-1:0]          scale_z;
        logic [LEN_W-1:0]          scale_y;
        logic [LEN_W-1:0]          scale_x;
    } out_t;

    function automatic logic signed [ANGLE_W-1:0] round_angle(
        input logic signed [ZW-1:0] z
    );
        logic signed [ZW-1:0] r;
        r = (z + HALF_Z) >>> RND_SH;
        if (r > HI_Z) begin
            r = HI_Z;
        end else if (r < LO_Z) begin
            r = LO_Z;
        end
        return r[ANGLE_W-1:0];
    endfunction

    // Flow control: the pipeline moves while the skid register is empty
    logic en;
    logic out_vld_reg;
    logic sk_vld_reg;
    out_t out_data_reg;
    out_t sk_data_reg;

    assign en       = !sk_vld_reg;
    assign s_tready = en;

    // Configuration register
    logic [TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // Valid bits travel alongside the data
    logic [VLD_N-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_tvalid};
        end
    end

    // Stage 0: capture the item, decide rejection on |w_elem|
    logic signed [ELEM_W-1:0] w_in;
    logic        [ELEM_W-1:0] w_mag;
    logic signed [ELEM_W-1:0] m_reg [9];
    logic                     rej_reg;

    assign w_in  = s_tdata[9*ELEM_W +: ELEM_W];
    assign w_mag = w_in[ELEM_W-1] ? (~w_in + 1'b1) : w_in;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                m_reg[j] <= s_tdata[j*ELEM_W +: ELEM_W];
            end
            rej_reg <= (w_mag <= ELEM_W'(tol_reg));
        end
    end

    // Stage 1: squares; stage 2: sums of squares per column
    logic [LEN_SQ_W-1:0] sq_reg  [9];
    logic [LEN_SQ_W-1:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                sq_reg[j] <= 64'(m_reg[j]) * 64'(m_reg[j]);
            end
            for (int c = 0; c < 3; c++) begin
                sum_reg[c] <= sq_reg[3*c] + sq_reg[3*c+1] + sq_reg[3*c+2];
            end
        end
    end

    // Column lengths
    logic [LEN_W-1:0] len_w [3];

    for (genvar c = 0; c < 3; c++) begin : g_len
        mseu_isqrt #(
            .IN_W (LEN_SQ_W)
        ) u_len_sqrt (
            .aclk   (aclk),
            .en     (en),
            .rad_i  (sum_reg[c]),
            .root_o (len_w[c])
        );
    end

    // Hold the elements that feed the angles until the lengths are out
    localparam int MD_W = 7 * ELEM_W + 1;
    logic [MD_W-1:0] md_in, md_out;

    assign md_in = {rej_reg, m_reg[8], m_reg[6], m_reg[5], m_reg[4],
                    m_reg[2], m_reg[1], m_reg[0]};

    mseu_delay #(
        .W (MD_W),
        .D (ST_A)
    ) u_elem_dly (
        .aclk (aclk),
        .en   (en),
        .d_i  (md_in),
        .d_o  (md_out)
    );

    logic signed [ELEM_W-1:0] e0_a, e1_a, e2_a, e4_a, e5_a, e6_a, e8_a;
    logic                     rej_a;

    assign {rej_a, e8_a, e6_a, e5_a, e4_a, e2_a, e1_a, e0_a} = md_out;

    // Status and scales wait for the angles
    meta_t meta_a, meta_d;

    assign meta_a.rej      = rej_a;
    assign meta_a.zero_len = (len_w[0] == '0) || (len_w[1] == '0) || (len_w[2] == '0);
    assign meta_a.len_x    = len_w[0];
    assign meta_a.len_y    = len_w[1];
    assign meta_a.len_z    = len_w[2];

    mseu_delay #(
        .W ($bits(meta_t)),
        .D (ST_D - ST_A)
    ) u_meta_dly (
        .aclk (aclk),
        .en   (en),
        .d_i  (meta_a),
        .d_o  (meta_d)
    );

    // Normalize the elements in use to Q2.30
    logic signed [NORM_W-1:0] n0_b, n1_b, n2_b, n4_b, n5_b, n6_b, n8_b;

    mseu_div u_div0 (.aclk(aclk), .en(en), .elem_i(e0_a), .den_i(len_w[0]), .quo_o(n0_b));
    mseu_div u_div1 (.aclk(aclk), .en(en), .elem_i(e1_a), .den_i(len_w[0]), .quo_o(n1_b));
    mseu_div u_div2 (.aclk(aclk), .en(en), .elem_i(e2_a), .den_i(len_w[0]), .quo_o(n2_b));
    mseu_div u_div4 (.aclk(aclk), .en(en), .elem_i(e4_a), .den_i(len_w[1]), .quo_o(n4_b));
    mseu_div u_div5 (.aclk(aclk), .en(en), .elem_i(e5_a), .den_i(len_w[1]), .quo_o(n5_b));
    mseu_div u_div6 (.aclk(aclk), .en(en), .elem_i(e6_a), .den_i(len_w[2]), .quo_o(n6_b));
    mseu_div u_div8 (.aclk(aclk), .en(en), .elem_i(e8_a), .den_i(len_w[2]), .quo_o(n8_b));

    // Cosine of rot_y: sqrt(1 - s*s) with s = -n0z; the square is the same for n0z
    logic [63:0]       s_sq_reg;
    logic [C_SQ_W-1:0] c_rad_reg;
    logic [C_W-1:0]    c_w;

    always_ff @(posedge aclk) begin
        if (en) begin
            s_sq_reg  <= 64'(n2_b) * 64'(n2_b);
            c_rad_reg <= C_SQ_W'(UNIT_SQ - s_sq_reg);
        end
    end

    mseu_isqrt #(
        .IN_W (C_SQ_W)
    ) u_cos_sqrt (
        .aclk   (aclk),
        .en     (en),
        .rad_i  (c_rad_reg),
        .root_o (c_w)
    );

    // Hold the normalized terms until the cosine is out
    localparam int ND_W = 7 * NORM_W;
    logic [ND_W-1:0] nd_out;

    mseu_delay #(
        .W (ND_W),
        .D (ST_C - ST_B)
    ) u_norm_dly (
        .aclk (aclk),
        .en   (en),
        .d_i  ({n8_b, n6_b, n5_b, n4_b, n2_b, n1_b, n0_b}),
        .d_o  (nd_out)
    );

    logic signed [NORM_W-1:0] n0_c, n1_c, n2_c, n4_c, n5_c, n6_c, n8_c;

    assign {n8_c, n6_c, n5_c, n4_c, n2_c, n1_c, n0_c} = nd_out;

    // Pick the angle operands; in gimbal lock (cosine zero) use the alternate rot_x
    // and feed rot_z a zero vector, which the CORDIC reports as angle zero
    logic                     gimbal;
    logic signed [NORM_W-1:0] ry_y, ry_x, rx_y, rx_x, rz_y, rz_x;

    always_comb begin
        gimbal = (c_w == '0);
        ry_y   = -n2_c;
        ry_x   = $signed(NORM_W'(c_w));
        if (gimbal) begin
            rx_y = -n6_c;
            rx_x = n4_c;
            rz_y = '0;
            rz_x = '0;
        end else begin
            rx_y = n5_c;
            rx_x = n8_c;
            rz_y = n1_c;
            rz_x = n0_c;
        end
    end

    logic signed [ZW-1:0] rx_z, ry_z, rz_z;

    mseu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_x (
        .aclk (aclk), .en (en), .y_i (rx_y), .x_i (rx_x), .z_o (rx_z)
    );
    mseu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_y (
        .aclk (aclk), .en (en), .y_i (ry_y), .x_i (ry_x), .z_o (ry_z)
    );
    mseu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_z (
        .aclk (aclk), .en (en), .y_i (rz_y), .x_i (rz_x), .z_o (rz_z)
    );

    // Assemble the result item: rejected items carry no scales, failed items no angles
    logic pipe_vld;
    out_t pipe_out;

    assign pipe_vld = vld_reg[VLD_N-1];

    always_comb begin
        if (meta_d.rej) begin
            pipe_out.status = STATUS_REJECT;
        end else if (meta_d.zero_len) begin
            pipe_out.status = STATUS_ZERO_LEN;
        end else begin
            pipe_out.status = STATUS_OK;
        end
        pipe_out.scale_x = meta_d.rej ? '0 : meta_d.len_x;
        pipe_out.scale_y = meta_d.rej ? '0 : meta_d.len_y;
        pipe_out.scale_z = meta_d.rej ? '0 : meta_d.len_z;
        if (pipe_out.status == STATUS_OK) begin
            pipe_out.rot_x = round_angle(rx_z);
            pipe_out.rot_y = round_angle(ry_z);
            pipe_out.rot_z = round_angle(rz_z);
        end else begin
            pipe_out.rot_x = '0;
            pipe_out.rot_y = '0;
            pipe_out.rot_z = '0;
        end
    end

    // Output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
            sk_vld_reg  <= 1'b0;
        end else begin
            if (sk_vld_reg) begin
                // drain the skid item once the held one is taken
                if (m_tready) begin
                    out_data_reg <= sk_data_reg;
                    sk_vld_reg   <= 1'b0;
                end
            end else if (!out_vld_reg || m_tready) begin
                out_vld_reg  <= pipe_vld;
                out_data_reg <= pipe_out;
            end else if (pipe_vld) begin
                // output stalled: park the arriving item
                sk_data_reg <= pipe_out;
                sk_vld_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {7'b0, out_data_reg.rot_z, out_data_reg.rot_y, out_data_reg.rot_x,
                       out_data_reg.scale_z, out_data_reg.scale_y, out_data_reg.scale_x};

endmodule

### verif/matrix_scale_euler_decompose_tb.sv
module matrix_scale_euler_decompose_tb;
    import mseu_pkg::*;

    localparam int  PIPE_LAT    = 102 + CORDIC_STEPS_DEF;
    localparam longint MAX_CYC  = 2000000;
    localparam longint UNIT     = 64'sd1073741824;
    localparam longint HALF_PI  = 64'sd1686629713;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sx, sy, sz;
        logic [18:0] rx, ry, rz;
    } decomp_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [TOL_W-1:0] cfg_data = '0;

    logic [15:0] tol_shadow = 0;
    decomp_t     expected_q[$];
    int          fail_cnt = 0;
    longint      cyc = 0;
    bit          rx_idle_en = 0;
    bit          tx_idle_en = 0;
    bit          hold_req = 0;
    bit          hold_done = 0;
    int          hold_off = 0;
    int          rx_gap = 0;

    matrix_scale_euler_decompose dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: bail out if the run never drains.
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > MAX_CYC) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint z, t, dx, dy, a;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = y; y = -x; x = t; z = HALF_PI;
            end else begin
                t = -y; y = x; x = t; z = -HALF_PI;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            a = longint'(atan_q30(5'(i)));
            if (y >= 0) begin
                x += dx; y -= dy; z += a;
            end else begin
                x -= dx; y += dy; z -= a;
            end
        end
        return z;
    endfunction

    function automatic logic [18:0] to_radians(longint z);
        int sh;
        longint half, lim, r;
        sh = 30 - FRAC_BITS_DEF;
        half = 64'sd1 << (sh - 1);
        lim = (PI_Q30 + half) >>> sh;
        r = floor_shr(z + half, sh);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        if (r > 262143) r = 262143;
        if (r < -262144) r = -262144;
        return r[18:0];
    endfunction

    function automatic longint unit_comp(longint v, longint len);
        logic [63:0] mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag << 30) / len;
        if (q > UNIT) q = UNIT;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Compute scales and XYZ Euler angles of one matrix item.
    function automatic decomp_t decompose(logic [IN_DATA_W-1:0] d);
        decomp_t r;
        longint m[9], len[3], n[9];
        longint w, s, c, ax, ay, az;
        logic [63:0] sq;
        r = '0;
        for (int j = 0; j < 9; j++) m[j] = longint'($signed(d[32*j +: 32]));
        w = longint'($signed(d[288 +: 32]));
        if (((w < 0) ? -w : w) <= longint'(tol_shadow)) begin
            r.status = STATUS_REJECT;
            return r;
        end
        for (int j = 0; j < 3; j++) begin
            sq = m[3*j]*m[3*j] + m[3*j+1]*m[3*j+1] + m[3*j+2]*m[3*j+2];
            len[j] = int_root(sq);
            if (len[j] > 64'hFFFFFFFF) len[j] = 64'hFFFFFFFF;
        end
        r.sx = len[0][31:0]; r.sy = len[1][31:0]; r.sz = len[2][31:0];
        if (len[0] == 0 || len[1] == 0 || len[2] == 0) begin
            r.status = STATUS_ZERO_LEN;
            return r;
        end
        for (int j = 0; j < 9; j++) n[j] = unit_comp(m[j], len[j/3]);
        s = -n[2];
        c = int_root(UNIT*UNIT - s*s);
        ay = cordic_angle(s, c);
        if (c != 0) begin
            ax = cordic_angle(n[5], n[8]);
            az = cordic_angle(n[1], n[0]);
        end else begin
            ax = cordic_angle(-n[6], n[4]);
            az = 0;
        end
        r.status = STATUS_OK;
        r.rx = to_radians(ax);
        r.ry = to_radians(ay);
        r.rz = to_radians(az);
        return r;
    endfunction

    // Result side: short random stalls, plus one long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1;
            hold_off  <= 3 * PIPE_LAT - 1;
            m_tready  <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 0;
        end else if (rx_idle_en && m_tready && $urandom_range(0, 5) == 0) begin
            rx_gap   <= int'($urandom_range(0, 2));
            m_tready <= 0;
        end else begin
            m_tready <= aresetn;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        decomp_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.sx = m_tdata[31:0];
            got.sy = m_tdata[63:32];
            got.sz = m_tdata[95:64];
            got.rx = m_tdata[114:96];
            got.ry = m_tdata[133:115];
            got.rz = m_tdata[152:134];
            if (expected_q.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); fail_cnt++;
                end
                if (got.sx !== want.sx) begin
                    $error("scale_x exp %0d got %0d", want.sx, got.sx); fail_cnt++;
                end
                if (got.sy !== want.sy) begin
                    $error("scale_y exp %0d got %0d", want.sy, got.sy); fail_cnt++;
                end
                if (got.sz !== want.sz) begin
                    $error("scale_z exp %0d got %0d", want.sz, got.sz); fail_cnt++;
                end
                if (got.rx !== want.rx) begin
                    $error("rot_x exp %0d got %0d", $signed(want.rx), $signed(got.rx));
                    fail_cnt++;
                end
                if (got.ry !== want.ry) begin
                    $error("rot_y exp %0d got %0d", $signed(want.ry), $signed(got.ry));
                    fail_cnt++;
                end
                if (got.rz !== want.rz) begin
                    $error("rot_z exp %0d got %0d", $signed(want.rz), $signed(got.rz));
                    fail_cnt++;
                end
            end
        end
    end

    // Offer one item, hold it until accepted, then queue its expectation.
    task automatic send_matrix(logic [IN_DATA_W-1:0] d);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(decompose(d));
    endtask

    task automatic go_quiet();
        s_tvalid <= 0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT / 4) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        tol_shadow = v;
    endtask

    function automatic logic [IN_DATA_W-1:0] pack(longint e[10]);
        logic [IN_DATA_W-1:0] d;
        for (int j = 0; j < 10; j++) d[32*j +: 32] = e[j][31:0];
        return d;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            3: return '0;
            4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // Random matrix: columns of mixed magnitude, sometimes with column 0 forced to a pure z axis
    // so gimbal lock shows up, and sometimes with one column zeroed.
    function automatic logic [IN_DATA_W-1:0] rand_matrix();
        longint e[10];
        for (int j = 0; j < 9; j++) e[j] = $signed(rand_elem());
        if ($urandom_range(0, 7) == 0) begin
            e[0] = 0; e[1] = 0;
            e[2] = $urandom_range(0, 1) ? 65536 : -65536;
        end
        if ($urandom_range(0, 15) == 0) begin
            int k;
            k = $urandom_range(0, 2);
            e[3*k] = 0; e[3*k+1] = 0; e[3*k+2] = 0;
        end
        e[9] = $urandom_range(0, 3) == 0 ? longint'($signed($urandom_range(0, 400)) - 200)
                                          : longint'($signed($urandom()));
        return pack(e);
    endfunction

    task automatic test_directed();
        longint e[10];
        longint ext[4] = '{32'sh7FFFFFFF, -32'sh80000000, 65536, -65536};
        // Identity, then each extreme on every element.
        e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 65536};
        send_matrix(pack(e));
        foreach (ext[k]) begin
            for (int j = 0; j < 10; j++) e[j] = ext[k];
            send_matrix(pack(e));
        end
        // Gimbal lock both ways.
        e = '{0, 0, 65536, 0, 65536, 0, -65536, 0, 0, 65536};
        send_matrix(pack(e));
        e = '{0, 0, -65536, 0, 65536, 0, 65536, 0, 0, 65536};
        send_matrix(pack(e));
        // Zero-length column, each column in turn.
        for (int k = 0; k < 3; k++) begin
            e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 65536};
            e[3*k] = 0; e[3*k+1] = 0; e[3*k+2] = 0;
            send_matrix(pack(e));
        end
        // atan2(0, negative), w near zero and w at its most negative.
        e = '{-65536, 0, 0, 0, -65536, 0, 0, 0, -65536, -1};
        send_matrix(pack(e));
        e = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 0};
        send_matrix(pack(e));
        e[9] = -32'sh80000000;
        send_matrix(pack(e));
        go_quiet();
    endtask

    task automatic test_tolerance_sweep();
        logic [15:0] tols[4] = '{16'hFFFF, 16'd1, 16'd100, 16'd0};
        foreach (tols[t]) begin
            write_tolerance(tols[t]);
            for (int i = 0; i < 30; i++) send_matrix(rand_matrix());
            go_quiet();
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int i = 0; i < 200; i++) send_matrix(rand_matrix());
        go_quiet();
    endtask

    task automatic test_random();
        write_tolerance(16'($urandom_range(0, 300)));
        for (int i = 0; i < 700; i++) send_matrix(rand_matrix());
        go_quiet();
        // Last stretch: no idling on either side.
        tx_idle_en = 0;
        rx_idle_en = 0;
        write_tolerance(16'($urandom()));
        for (int i = 0; i < 200; i++) send_matrix(rand_matrix());
        go_quiet();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        tx_idle_en = 1;
        rx_idle_en = 1;
        test_directed();
        test_tolerance_sweep();
        test_backpressure();
        test_random();
        repeat (PIPE_LAT) @(posedge aclk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
